FILE: hw/rtl/ccr_pkg.sv
// shared types and constants of the coprocessor control register block
// beat structs, register map, status bit layout and the clear/set pair helper
// no dependencies
package ccr_pkg;

    localparam int ADDR_W = 18;
    localparam int DATA_W = 32;

    // access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // dma start command codes
    localparam logic [1:0] DMA_NONE     = 2'd0;
    localparam logic [1:0] DMA_TO_LOCAL = 2'd1;
    localparam logic [1:0] DMA_TO_MAIN  = 2'd2;

    // register map, word index within the block
    typedef enum logic [2:0] {
        REG_LOCAL_ADDR = 3'd0,
        REG_MAIN_ADDR  = 3'd1,
        REG_IN_LENGTH  = 3'd2,
        REG_OUT_LENGTH = 3'd3,
        REG_STATUS     = 3'd4,
        REG_DMA_FULL   = 3'd5,
        REG_DMA_BUSY   = 3'd6,
        REG_SEMAPHORE  = 3'd7
    } t_ccr_reg;

    // status write layout
    localparam int SW_HALT_CLR   = 0;
    localparam int SW_HALT_SET   = 1;
    localparam int SW_BROKEN_CLR = 2;
    localparam int SW_IRQ_LOWER  = 3;
    localparam int SW_IRQ_RAISE  = 4;
    localparam int SW_STEP_CLR   = 5;
    localparam int SW_STEP_SET   = 6;
    localparam int SW_BIRQ_CLR   = 7;
    localparam int SW_BIRQ_SET   = 8;
    localparam int SW_SIG_BASE   = 9;
    localparam int NUM_SIGNALS   = 8;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              dma_busy;
        logic              dma_full;
        logic              io_full;
        logic              break_set;
    } t_ccr_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        dma_start;
        logic              dma_local_select;
        logic [11:0]       dma_local_address;
        logic [23:0]       dma_main_address;
        logic [12:0]       dma_line_bytes;
        logic [8:0]        dma_line_count;
        logic [11:0]       dma_line_skip;
        logic              irq_raise;
        logic              irq_lower;
        logic              halted_now;
        logic              single_step_now;
    } t_ccr_out;

    // clear/set pair, set wins
    function automatic logic pair_update(input logic cur, input logic clr, input logic set);
        logic res;
        res = cur;
        if (clr) res = 1'b0;
        if (set) res = 1'b1;
        return res;
    endfunction

endpackage

FILE: hw/rtl/ccr_regs.sv
// register file and access decode of the coprocessor control register block
// computes one result beat from the staged access and updates state on fire
// depends on ccr_pkg
module ccr_regs
    import ccr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_ccr_in  i_item,
    output t_ccr_out o_result
);

    logic [11:0] r_local_addr, n_local_addr;
    logic        r_local_sel, n_local_sel;
    logic [23:0] r_main_addr, n_main_addr;
    logic [31:0] r_in_len, n_in_len;
    logic [31:0] r_out_len, n_out_len;
    logic        r_halted, n_halted;
    logic        r_broken, n_broken;
    logic        r_step, n_step;
    logic        r_birq_en, n_birq_en;
    logic [NUM_SIGNALS-1:0] r_signals, n_signals;
    logic        r_sema, n_sema;

    logic        known;
    t_ccr_reg    sel;
    logic [31:0] d;
    logic [31:0] rd;
    logic [1:0]  start;
    logic        raise, lower;
    logic        broken_pre;

    assign known = (i_item.address[ADDR_W-1:5] == '0);
    assign sel   = t_ccr_reg'(i_item.address[4:2]);
    assign d     = i_item.write_data;
    // break event lands before the access
    assign broken_pre = r_broken | i_item.break_set;

    always_comb begin
        n_local_addr = r_local_addr;
        n_local_sel  = r_local_sel;
        n_main_addr  = r_main_addr;
        n_in_len     = r_in_len;
        n_out_len    = r_out_len;
        n_halted     = r_halted;
        n_broken     = broken_pre;
        n_step       = r_step;
        n_birq_en    = r_birq_en;
        n_signals    = r_signals;
        n_sema       = r_sema;
        rd           = '0;
        start        = DMA_NONE;
        raise        = 1'b0;
        lower        = 1'b0;

        if (known) begin
            if (i_item.func == FUNC_READ) begin
                case (sel)
                    REG_LOCAL_ADDR: rd = {19'd0, r_local_sel, r_local_addr};
                    REG_MAIN_ADDR:  rd = {8'd0, r_main_addr};
                    REG_IN_LENGTH:  rd = r_in_len;
                    REG_OUT_LENGTH: rd = r_out_len;
                    REG_STATUS: begin
                        rd = {17'd0, r_signals, r_birq_en, r_step, i_item.io_full,
                              i_item.dma_full, i_item.dma_busy, broken_pre, r_halted};
                    end
                    REG_DMA_FULL:   rd = {31'd0, i_item.dma_full};
                    REG_DMA_BUSY:   rd = {31'd0, i_item.dma_busy};
                    REG_SEMAPHORE: begin
                        rd     = {31'd0, r_sema};
                        n_sema = 1'b1;
                    end
                    default:        rd = '0;
                endcase
            end else begin
                case (sel)
                    REG_LOCAL_ADDR: begin
                        n_local_addr = d[11:0];
                        n_local_sel  = d[12];
                    end
                    REG_MAIN_ADDR:  n_main_addr = d[23:0];
                    REG_IN_LENGTH: begin
                        n_in_len = d;
                        start    = DMA_TO_LOCAL;
                    end
                    REG_OUT_LENGTH: begin
                        n_out_len = d;
                        start     = DMA_TO_MAIN;
                    end
                    REG_STATUS: begin
                        n_halted = pair_update(r_halted, d[SW_HALT_CLR], d[SW_HALT_SET]);
                        if (d[SW_BROKEN_CLR]) n_broken = 1'b0;
                        raise    = d[SW_IRQ_RAISE];
                        lower    = d[SW_IRQ_LOWER] & ~d[SW_IRQ_RAISE];
                        n_step   = pair_update(r_step, d[SW_STEP_CLR], d[SW_STEP_SET]);
                        n_birq_en = pair_update(r_birq_en, d[SW_BIRQ_CLR], d[SW_BIRQ_SET]);
                        for (int i = 0; i < NUM_SIGNALS; i++) begin
                            n_signals[i] = pair_update(r_signals[i],
                                                       d[SW_SIG_BASE + 2*i],
                                                       d[SW_SIG_BASE + 2*i + 1]);
                        end
                    end
                    REG_SEMAPHORE: begin
                        if (!d[0]) n_sema = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_result                 = '0;
        o_result.read_data       = rd;
        o_result.dma_start       = start;
        o_result.irq_raise       = raise;
        o_result.irq_lower       = lower;
        o_result.halted_now      = n_halted;
        o_result.single_step_now = n_step;
        if (start != DMA_NONE) begin
            o_result.dma_local_select  = r_local_sel;
            o_result.dma_local_address = {r_local_addr[11:3], 3'b000};
            o_result.dma_main_address  = {r_main_addr[23:3], 3'b000};
            o_result.dma_line_bytes    = {1'b0, d[11:3], 3'b111} + 13'd1;
            o_result.dma_line_count    = {1'b0, d[19:12]} + 9'd1;
            o_result.dma_line_skip     = d[31:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
            r_local_sel  <= 1'b0;
            r_main_addr  <= '0;
            r_in_len     <= '0;
            r_out_len    <= '0;
            r_halted     <= 1'b1;
            r_broken     <= 1'b0;
            r_step       <= 1'b0;
            r_birq_en    <= 1'b0;
            r_signals    <= '0;
            r_sema       <= 1'b0;
        end else if (i_fire) begin
            r_local_addr <= n_local_addr;
            r_local_sel  <= n_local_sel;
            r_main_addr  <= n_main_addr;
            r_in_len     <= n_in_len;
            r_out_len    <= n_out_len;
            r_halted     <= n_halted;
            r_broken     <= n_broken;
            r_step       <= n_step;
            r_birq_en    <= n_birq_en;
            r_signals    <= n_signals;
            r_sema       <= n_sema;
        end
    end

endmodule

FILE: hw/rtl/coprocessor_control_registers_unit.sv
// coprocessor control register block: input register then result register, one access
// per cycle sustained unless the result channel stalls; the input register feeds the
// decode in ccr_regs; result register holds the answer while the next access is staged.
// synchronous active-low reset clears both stage valids and loads register reset
// values (halted set, everything else zero); no clearing pass, ready right after reset
// depends on ccr_pkg and ccr_regs
module coprocessor_control_registers_unit
    import ccr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // access channel
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ccr_in  i_in_data,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ccr_out o_out_data
);

    // stage 1: staged access
    logic     r_in_valid;
    t_ccr_in  r_in;
    // stage 2: result beat
    logic     r_out_valid;
    t_ccr_out r_out;

    logic     out_free;
    logic     fire;
    logic     in_take;
    t_ccr_out result;

    // result register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // staged access executes and commits its state update
    assign fire     = r_in_valid && out_free;
    // stage 1 refills whenever it is empty or its beat moves on
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    ccr_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: tb/coprocessor_control_registers_unit_tb.sv
// self-checking testbench for coprocessor_control_registers_unit: directed register accesses
// then paced random beats, each result checked against a cycle-free register mirror
// depends on ccr_pkg and the coprocessor_control_registers_unit rtl
module coprocessor_control_registers_unit_tb;
    import ccr_pkg::*;

    // register mirror: keeps its own copy of the register state, works out the
    // result of every accepted access beat and checks result beats in order
    class ccr_register_mirror;
        logic [11:0] local_addr;
        logic        local_sel;
        logic [23:0] main_addr;
        logic [31:0] in_len;
        logic [31:0] out_len;
        logic        halted;
        logic        broken;
        logic        step;
        logic        birq_en;
        logic [7:0]  signals;
        logic        semaphore;
        t_ccr_out    expected_q[$];
        int unsigned failures;

        function new();
            local_addr = '0;
            local_sel  = 1'b0;
            main_addr  = '0;
            in_len     = '0;
            out_len    = '0;
            halted     = 1'b1;
            broken     = 1'b0;
            step       = 1'b0;
            birq_en    = 1'b0;
            signals    = '0;
            semaphore  = 1'b0;
            failures   = 0;
        endfunction

        // clear/set bit pair, the set bit wins
        function logic set_wins(logic cur, logic clr_bit, logic set_bit);
            return set_bit | (cur & ~clr_bit);
        endfunction

        function void note_access(t_ccr_in a);
            t_ccr_out    r;
            logic [15:0] word;
            logic [31:0] d;
            t_ccr_reg    idx;
            logic        known;
            int          i;
            r     = '0;
            d     = a.write_data;
            word  = a.address[ADDR_W-1:2];
            idx   = t_ccr_reg'(word[2:0]);
            known = (word <= 16'd7);

            // break event lands before the access itself
            if (a.break_set) broken = 1'b1;

            if (known && a.func == FUNC_READ) begin
                case (idx)
                    REG_LOCAL_ADDR: r.read_data = {19'd0, local_sel, local_addr};
                    REG_MAIN_ADDR:  r.read_data = {8'd0, main_addr};
                    REG_IN_LENGTH:  r.read_data = in_len;
                    REG_OUT_LENGTH: r.read_data = out_len;
                    REG_STATUS:     r.read_data = {17'd0, signals, birq_en, step, a.io_full,
                                                   a.dma_full, a.dma_busy, broken, halted};
                    REG_DMA_FULL:   r.read_data = {31'd0, a.dma_full};
                    REG_DMA_BUSY:   r.read_data = {31'd0, a.dma_busy};
                    REG_SEMAPHORE: begin
                        // old value out, then taken
                        r.read_data = {31'd0, semaphore};
                        semaphore   = 1'b1;
                    end
                    default:        r.read_data = '0;
                endcase
            end else if (known) begin
                case (idx)
                    REG_LOCAL_ADDR: begin
                        local_addr = d[11:0];
                        local_sel  = d[12];
                    end
                    REG_MAIN_ADDR:  main_addr = d[23:0];
                    REG_IN_LENGTH: begin
                        in_len      = d;
                        r.dma_start = DMA_TO_LOCAL;
                    end
                    REG_OUT_LENGTH: begin
                        out_len     = d;
                        r.dma_start = DMA_TO_MAIN;
                    end
                    REG_STATUS: begin
                        halted = set_wins(halted, d[SW_HALT_CLR], d[SW_HALT_SET]);
                        if (d[SW_BROKEN_CLR]) broken = 1'b0;
                        r.irq_raise = d[SW_IRQ_RAISE];
                        r.irq_lower = d[SW_IRQ_LOWER] & ~d[SW_IRQ_RAISE];
                        step    = set_wins(step, d[SW_STEP_CLR], d[SW_STEP_SET]);
                        birq_en = set_wins(birq_en, d[SW_BIRQ_CLR], d[SW_BIRQ_SET]);
                        for (i = 0; i < NUM_SIGNALS; i++) begin
                            signals[i] = set_wins(signals[i], d[SW_SIG_BASE + 2*i],
                                                  d[SW_SIG_BASE + 2*i + 1]);
                        end
                    end
                    REG_SEMAPHORE: if (!d[0]) semaphore = 1'b0;
                    default: ; // busy and full flags are read-only
                endcase
            end

            if (r.dma_start != DMA_NONE) begin
                r.dma_local_select  = local_sel;
                r.dma_local_address = {local_addr[11:3], 3'b000};
                r.dma_main_address  = {main_addr[23:3], 3'b000};
                r.dma_line_bytes    = {1'b0, d[11:0] | 12'h007} + 13'd1;
                r.dma_line_count    = {1'b0, d[19:12]} + 9'd1;
                r.dma_line_skip     = d[31:20];
            end
            r.halted_now      = halted;
            r.single_step_now = step;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
            if (got_val !== exp_val) begin
                failures++;
                $display("%0t: %s mismatch, expected %h, got %h",
                         $time, name, exp_val, got_val);
            end
        endfunction

        function void check_result(t_ccr_out got);
            t_ccr_out e;
            if (expected_q.size() == 0) begin
                failures++;
                $display("%0t: result beat with no access pending, expected none, got %h",
                         $time, got);
                return;
            end
            e = expected_q.pop_front();
            compare_field("read_data", e.read_data, got.read_data);
            compare_field("dma_start", 32'(e.dma_start), 32'(got.dma_start));
            compare_field("dma_local_select", 32'(e.dma_local_select),
                          32'(got.dma_local_select));
            compare_field("dma_local_address", 32'(e.dma_local_address),
                          32'(got.dma_local_address));
            compare_field("dma_main_address", 32'(e.dma_main_address),
                          32'(got.dma_main_address));
            compare_field("dma_line_bytes", 32'(e.dma_line_bytes), 32'(got.dma_line_bytes));
            compare_field("dma_line_count", 32'(e.dma_line_count), 32'(got.dma_line_count));
            compare_field("dma_line_skip", 32'(e.dma_line_skip), 32'(got.dma_line_skip));
            compare_field("irq_raise", 32'(e.irq_raise), 32'(got.irq_raise));
            compare_field("irq_lower", 32'(e.irq_lower), 32'(got.irq_lower));
            compare_field("halted_now", 32'(e.halted_now), 32'(got.halted_now));
            compare_field("single_step_now", 32'(e.single_step_now),
                          32'(got.single_step_now));
        endfunction
    endclass

    localparam int RANDOM_BEATS = 1250;

    // every block input starts at a known value
    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_ccr_in  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_ccr_out o_out_data;

    ccr_register_mirror mirror;

    // sender pacing
    int unsigned burst_left = 0;
    // receiver stall pattern
    int unsigned stall_mode = 0;
    int unsigned stall_run  = 0;
    int unsigned stall_tick = 0;

    coprocessor_control_registers_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, well beyond the slowest legal run
    initial begin
        #3000000;
        $display("coprocessor_control_registers_unit verification failed");
        $finish;
    end

    // handshakes are sampled in the active region of the edge, before any
    // nonblocking update, so both sides see the pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) mirror.note_access(i_in_data);
            if (o_out_valid && !i_out_stall) mirror.check_result(o_out_data);
        end
    end

    // receiver stalls in modes that change after runs of random length:
    // free flowing, light random, heavy random and a fixed periodic stall
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(16, 128);
        end
        stall_run--;
        stall_tick++;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    function automatic logic [ADDR_W-1:0] reg_addr(t_ccr_reg r);
        return {13'd0, r, 2'b00};
    endfunction

    // flags: {dma_busy, dma_full, io_full, break_set}
    function automatic t_ccr_in make_access(logic func, logic [ADDR_W-1:0] addr,
                                            logic [DATA_W-1:0] data, logic [3:0] flags);
        t_ccr_in a;
        a.func       = func;
        a.address    = addr;
        a.write_data = data;
        a.dma_busy   = flags[3];
        a.dma_full   = flags[2];
        a.io_full    = flags[1];
        a.break_set  = flags[0];
        return a;
    endfunction

    // one access beat, paced in bursts with random gaps in between;
    // returns at the edge where the beat is taken
    task automatic send_access(input t_ccr_in a);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= a;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random_access();
        t_ccr_in a;
        a.func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 8)
            a.address = ADDR_W'($urandom_range(0, 18'h3ffff));   // mostly outside the map
        else
            a.address = {13'd0, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))};
        a.write_data = $urandom();
        // sparse words now and then so single pairs get exercised alone
        if ($urandom_range(0, 2) == 0) a.write_data = a.write_data & $urandom() & $urandom();
        a.dma_busy  = 1'($urandom_range(0, 1));
        a.dma_full  = 1'($urandom_range(0, 1));
        a.io_full   = 1'($urandom_range(0, 1));
        a.break_set = ($urandom_range(0, 9) == 0);
        send_access(a);
    endtask

    initial begin
        mirror = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // status straight after reset, halted set
        send_access(make_access(FUNC_READ, reg_addr(REG_STATUS), 32'h0, 4'b0000));
        // extreme dma setup, then both length writes at opposite extremes
        send_access(make_access(FUNC_WRITE, reg_addr(REG_LOCAL_ADDR), 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_WRITE, reg_addr(REG_MAIN_ADDR), 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_WRITE, reg_addr(REG_IN_LENGTH), 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_WRITE, reg_addr(REG_OUT_LENGTH), 32'h0, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_LOCAL_ADDR), 32'h0, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_MAIN_ADDR), 32'h0, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_IN_LENGTH), 32'h0, 4'b0000));
        // every pair with both bits set: set wins, raise beats lower
        send_access(make_access(FUNC_WRITE, reg_addr(REG_STATUS), 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_STATUS), 32'h0, 4'b1110));
        // only the clear bits: everything drops, interrupt lowered
        send_access(make_access(FUNC_WRITE, reg_addr(REG_STATUS), 32'h00aa_aaad, 4'b0000));
        // break event seen by a read in the same beat
        send_access(make_access(FUNC_READ, reg_addr(REG_STATUS), 32'h0, 4'b0001));
        // break event and broken clear in one beat: clear wins
        send_access(make_access(FUNC_WRITE, reg_addr(REG_STATUS), 32'h0000_0004, 4'b0001));
        // semaphore: take, see taken, write one keeps it, write zero frees it
        send_access(make_access(FUNC_READ, reg_addr(REG_SEMAPHORE), 32'h0, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_SEMAPHORE), 32'h0, 4'b0000));
        send_access(make_access(FUNC_WRITE, reg_addr(REG_SEMAPHORE), 32'h0000_0001, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_SEMAPHORE), 32'h0, 4'b0000));
        send_access(make_access(FUNC_WRITE, reg_addr(REG_SEMAPHORE), 32'hffff_fffe, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_SEMAPHORE), 32'h0, 4'b0000));
        // writes to read-only flags go nowhere
        send_access(make_access(FUNC_WRITE, reg_addr(REG_DMA_FULL), 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_WRITE, reg_addr(REG_DMA_BUSY), 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_READ, reg_addr(REG_DMA_FULL), 32'h0, 4'b0100));
        send_access(make_access(FUNC_READ, reg_addr(REG_DMA_BUSY), 32'h0, 4'b1000));
        // outside the map, and low address bits that do not pick the register
        send_access(make_access(FUNC_WRITE, 18'h3ffff, 32'hffff_ffff, 4'b0000));
        send_access(make_access(FUNC_READ, 18'h00020, 32'h0, 4'b1111));
        send_access(make_access(FUNC_READ, 18'h00013, 32'h0, 4'b0000));

        repeat (RANDOM_BEATS) send_random_access();
        i_in_valid <= 1'b0;

        while (mirror.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mirror.failures == 0 && mirror.expected_q.size() == 0)
            $display("coprocessor_control_registers_unit verification clean");
        else
            $display("coprocessor_control_registers_unit verification failed");
        $finish;
    end

endmodule
